@@ hdl/multiscale_running_median_core_macros.svh @@
// Assertion helpers; every use expects clk and rst in scope.
`ifndef MULTISCALE_RUNNING_MEDIAN_CORE_MACROS_SVH
`define MULTISCALE_RUNNING_MEDIAN_CORE_MACROS_SVH

// same-cycle implication
`define MRM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MRM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/mrm_pkg.sv @@
`timescale 1ns / 1ps
package mrm_pkg;

  localparam int MAX_WINDOW_DEF  = 8;
  localparam int SAMPLE_BITS_DEF = 32;
  localparam int SAMPLE_W        = 32;
  localparam int OUT_W           = 32;

  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  typedef struct packed {
    logic push;
    logic load;
  } cell_ctrl_t;

endpackage

@@ hdl/mrm_cell.sv @@
`timescale 1ns / 1ps
module mrm_cell #(
  parameter int SB    = mrm_pkg::SAMPLE_BITS_DEF,
  parameter int AGE_W = 3,
  parameter int LEN   = mrm_pkg::MAX_WINDOW_DEF,
  parameter int IDX   = 0
) (
  input  logic                    clk,
  input  logic                    rst,
  input  mrm_pkg::cell_ctrl_t     ctrl,
  input  logic signed [SB-1:0]    sample,
  input  logic                    gt_left,
  input  logic                    after_left,
  input  logic signed [SB-1:0]    val_left,
  input  logic [AGE_W-1:0]        age_left,
  input  logic                    gt_right,
  input  logic signed [SB-1:0]    val_right,
  input  logic [AGE_W-1:0]        age_right,
  output logic signed [SB-1:0]    val,
  output logic [AGE_W-1:0]        age,
  output logic                    gt,
  output logic                    after
);
  import mrm_pkg::*;

  localparam bit HAS_LEFT  = (IDX > 0);
  localparam bit HAS_RIGHT = (IDX < LEN - 1);

  logic signed [SB-1:0] val_next;
  logic [AGE_W-1:0]     age_next;
  logic                 old;

  assign gt    = (val > sample);
  assign old   = (age == AGE_W'(LEN - 1));
  assign after = after_left | old;

  // before the oldest entry: shift right past the sample; from it on: shift left
  always_comb begin
    val_next = val;
    age_next = age;
    priority if (ctrl.load) begin
      val_next = sample;
      age_next = AGE_W'(IDX);
    end else if (ctrl.push) begin
      if (!after) begin
        if (gt) begin
          if (HAS_LEFT && gt_left) begin
            val_next = val_left;
            age_next = age_left + AGE_W'(1);
          end else begin
            val_next = sample;
            age_next = '0;
          end
        end else begin
          age_next = age + AGE_W'(1);
        end
      end else begin
        if (HAS_RIGHT && !gt_right) begin
          val_next = val_right;
          age_next = age_right + AGE_W'(1);
        end else if (old && HAS_LEFT && gt_left) begin
          val_next = val_left;
          age_next = age_left + AGE_W'(1);
        end else if (old || !gt) begin
          val_next = sample;
          age_next = '0;
        end else begin
          age_next = age + AGE_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      val <= '0;
      age <= AGE_W'(IDX);
    end else begin
      val <= val_next;
      age <= age_next;
    end
  end

endmodule

@@ hdl/mrm_window.sv @@
`timescale 1ns / 1ps
`include "multiscale_running_median_core_macros.svh"
module mrm_window #(
  parameter int SB    = mrm_pkg::SAMPLE_BITS_DEF,
  parameter int AGE_W = 3,
  parameter int LEN   = mrm_pkg::MAX_WINDOW_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mrm_pkg::cell_ctrl_t  ctrl,
  input  logic signed [SB-1:0] sample,
  output logic signed [SB-1:0] median
);
  import mrm_pkg::*;

  logic signed [SB-1:0] val_a   [LEN];
  logic [AGE_W-1:0]     age_a   [LEN];
  logic                 gt_a    [LEN];
  logic                 after_a [LEN];

  for (genvar i = 0; i < LEN; i++) begin : g_cell
    localparam int L = (i > 0) ? i - 1 : 0;
    localparam int R = (i < LEN - 1) ? i + 1 : LEN - 1;

    mrm_cell #(
      .SB    (SB),
      .AGE_W (AGE_W),
      .LEN   (LEN),
      .IDX   (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .sample     (sample),
      .gt_left    (gt_a[L]),
      .after_left ((i > 0) ? after_a[L] : 1'b0),
      .val_left   (val_a[L]),
      .age_left   (age_a[L]),
      .gt_right   (gt_a[R]),
      .val_right  (val_a[R]),
      .age_right  (age_a[R]),
      .val        (val_a[i]),
      .age        (age_a[i]),
      .gt         (gt_a[i]),
      .after      (after_a[i])
    );
  end

  assign median = val_a[LEN/2];

  for (genvar i = 0; i < LEN - 1; i++) begin : g_chk
    `MRM_ASSERT_NOW(a_sorted, 1'b1, val_a[i] <= val_a[i+1], "window out of order")
  end

endmodule

@@ hdl/mrm_div.sv @@
`timescale 1ns / 1ps
module mrm_div #(
  parameter int DW      = 38,
  parameter int DIVISOR = 63
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  output logic          busy,
  output logic [DW-1:0] quotient
);
  import mrm_pkg::*;

  // DIVISOR is 2^K-1: a*2^K+b = a*DIVISOR+(a+b), so fold until the rest fits in K bits
  localparam int            K    = $clog2(DIVISOR + 1);
  localparam logic [DW-1:0] MASK = DW'(DIVISOR);

  logic [DW-1:0] rem;
  logic [DW-1:0] hi;
  logic [DW-1:0] lo;

  assign hi = rem >> K;
  assign lo = rem & MASK;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy     <= 1'b1;
      rem      <= dividend;
      quotient <= '0;
    end else if (busy) begin
      if (hi != '0) begin
        quotient <= quotient + hi;
        rem      <= hi + lo;
      end else begin
        if (lo == MASK) begin
          quotient <= quotient + DW'(1);
        end
        busy <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/multiscale_running_median_core.sv @@
`timescale 1ns / 1ps
// Multiscale running median filter.
// Input channel (in_valid/in_ready): command and sample_value. Command 0
// filters the sample, command 1 loads every window with it and gives no result.
// Output channel (out_valid/out_ready): filtered_value, the weighted sum of
// the window medians divided by 2^(MAX_WINDOW-2)-1, rounded to nearest.
// Windows of length MAX_WINDOW down to 3 are rows of sorted cells; a transfer
// updates every row together. The medians are then folded in one per cycle,
// and the divider folds (MAX_WINDOW-2)-bit digits, one fold per cycle, until
// the rest fits in MAX_WINDOW-2 bits. A filter item passes from transfer through
// the fold and the divider to out_valid, and one item is in work at a time; a
// load only writes the rows of cells and leaves the core in its idle state.
// in_ready is high while no item is in work, also while a result waits.
// A stalled receiver holds the result; the next result waits in the divider.
// Reset clears all windows to zero with ages 0 upward and drops any result.
`include "multiscale_running_median_core_macros.svh"
module multiscale_running_median_core #(
  parameter int MAX_WINDOW  = mrm_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = mrm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                command,
  input  logic signed [mrm_pkg::SAMPLE_W-1:0] sample_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [mrm_pkg::OUT_W-1:0]    filtered_value
);
  import mrm_pkg::*;

  localparam int NUM_WIN = MAX_WINDOW - 2;
  localparam int AGE_W   = $clog2(MAX_WINDOW);
  localparam int ACC_W   = SAMPLE_BITS + NUM_WIN;
  localparam int DIVISOR = (1 << NUM_WIN) - 1;
  localparam int HALF    = DIVISOR / 2;
  localparam int CNT_W   = (NUM_WIN > 1) ? $clog2(NUM_WIN) : 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ACC  = 4'b0010,
    S_PREP = 4'b0100,
    S_DIV  = 4'b1000
  } state_t;

  state_t                        state;
  state_t                        state_next;
  logic [CNT_W-1:0]              cnt;
  logic signed [ACC_W-1:0]       acc;
  logic signed [ACC_W-1:0]       acc_next;
  logic                          neg;
  cell_ctrl_t                    ctrl;
  logic [63:0]                   raw64;
  logic signed [SAMPLE_BITS-1:0] sample_s;
  logic signed [SAMPLE_BITS-1:0] med [NUM_WIN];
  logic signed [SAMPLE_BITS-1:0] med_sel;
  logic [ACC_W-1:0]              mag;
  logic                          div_start;
  logic                          div_busy;
  logic [ACC_W-1:0]              quotient;
  logic signed [ACC_W-1:0]       res_w;
  logic signed [63:0]            res64;
  logic                          out_load;

  assign in_ready  = (state == S_IDLE);
  assign raw64     = 64'({sample_value});
  assign sample_s  = raw64[SAMPLE_BITS-1:0];
  assign ctrl.load = in_valid && in_ready && (command == CMD_LOAD);
  assign ctrl.push = in_valid && in_ready && (command == CMD_FILTER);

  for (genvar w = 0; w < NUM_WIN; w++) begin : g_win
    mrm_window #(
      .SB    (SAMPLE_BITS),
      .AGE_W (AGE_W),
      .LEN   (MAX_WINDOW - w)
    ) u_win (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (ctrl),
      .sample (sample_s),
      .median (med[w])
    );
  end

  always_comb begin
    med_sel = med[0];
    for (int w = 0; w < NUM_WIN; w++) begin
      if (cnt == CNT_W'(w)) begin
        med_sel = med[w];
      end
    end
  end

  // Horner fold: longest window ends up with weight 1
  assign acc_next  = (acc <<< 1) + ACC_W'(med_sel);
  assign mag       = (acc[ACC_W-1] ? $unsigned(-acc) : $unsigned(acc)) + ACC_W'(HALF);
  assign div_start = (state == S_PREP);
  assign res_w     = neg ? -$signed(quotient) : $signed(quotient);
  assign res64     = 64'(res_w);
  assign out_load  = (state == S_DIV) && !div_busy && (!out_valid || out_ready);

  mrm_div #(
    .DW      (ACC_W),
    .DIVISOR (DIVISOR)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag),
    .busy     (div_busy),
    .quotient (quotient)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (ctrl.push) state_next = S_ACC;
      S_ACC:  if (cnt == '0) state_next = S_PREP;
      S_PREP: state_next = S_DIV;
      S_DIV:  if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.push) begin
        cnt <= CNT_W'(NUM_WIN - 1);
        acc <= '0;
      end else if (state == S_ACC) begin
        acc <= acc_next;
        cnt <= cnt - CNT_W'(1);
      end
      if (state == S_PREP) begin
        neg <= acc[ACC_W-1];
      end
      if (out_load) begin
        out_valid      <= 1'b1;
        filtered_value <= res64[OUT_W-1:0];
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `MRM_ASSERT_NEXT(a_filter_starts, ctrl.push, state == S_ACC, "filter transfer did not start fold")
  `MRM_ASSERT_NEXT(a_div_runs, state == S_PREP, div_busy, "divider not started")
  `MRM_ASSERT_NEXT(a_out_held, (state == S_DIV) && !div_busy && out_valid && !out_ready, (state == S_DIV) && out_valid, "result overwrote pending output")

endmodule
